// File: sv/rtdc_pkg.sv
// Shared types and constants for the RTD code to temperature converter.
package rtdc_pkg;

    localparam int RES_W  = 16;
    localparam int TEMP_W = 15;
    localparam int CFG_W  = 16;

    // Register map of the configuration port.
    typedef enum logic [0:0] {
        REG_GAIN_SCALE      = 1'b0,
        REG_OFFSET_MILLIOHM = 1'b1
    } cfg_reg_t;

    localparam logic signed [CFG_W-1:0] GAIN_RESET   = 16'sd10000;
    localparam logic signed [CFG_W-1:0] OFFSET_RESET = 16'sd0;

    // Resistance numerator N, in units of 1/60000000 ohm.
    localparam int                 CODE_SLOPE   = 293;
    localparam logic signed [31:0] OFFSET_SCALE = 32'sd60000;
    localparam longint             RES_BIAS     = 64'sd80320000;
    localparam longint             N_LOW        = 64'sd6000000000;
    localparam longint             N_HIGH       = 64'sd23428800000;

    // Centiohm output: floor(N / 600000), with 600000 = 9375 * 2^6.
    localparam longint RES_DIV          = 64'sd600000;
    localparam longint RES_SAT          = (longint'(1) <<< RES_W) * RES_DIV;
    localparam int     RES_SHIFT        = 6;
    localparam longint RES_ODD          = 64'sd9375;
    localparam int     RES_X_W          = 30;
    localparam int     RES_MAGIC_SHIFT  = 44;
    localparam int     RES_MAGIC_W      = 31;
    localparam logic [RES_MAGIC_W-1:0] RES_MAGIC =
        RES_MAGIC_W'(((longint'(1) <<< RES_MAGIC_SHIFT) + RES_ODD - 1) / RES_ODD);
    localparam int     RES_PROD_W       = RES_X_W + RES_MAGIC_W;

    // Scaled discriminant E = E_ZERO - 231 * (N - N_LOW).
    localparam int               D_W      = 35;
    localparam int               E_W      = 44;
    localparam logic [E_W-1:0]   E_ZERO   = 44'd9164885334000;
    localparam logic [7:0]       CVD_B    = 8'd231;

    // Square root of E * 2^28 / 375, found bit by bit.
    localparam int               ROOT_W   = 32;
    localparam int               REM_W    = 74;
    localparam int               T_W      = 41;
    localparam int               SQ_SHIFT = 28;
    localparam logic [8:0]       SQ_SCALE = 9'd375;

    // Temperature = floor((S_ZERO - S) * 25 / 2^13 / 231).
    localparam logic [ROOT_W-1:0] S_ZERO     = 32'd2561343488;
    localparam logic [4:0]        TEMP_NUM   = 5'd25;
    localparam int                Y_W        = ROOT_W + 5;
    localparam int                TEMP_SHIFT = 13;
    localparam int                Z_W        = Y_W - TEMP_SHIFT;
    localparam int                DIV_SHIFT  = 32;
    localparam int                DIV_MAGIC_W = 25;
    localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC =
        DIV_MAGIC_W'(((longint'(1) <<< DIV_SHIFT) + 64'sd230) / 64'sd231);
    localparam int                M_W        = Z_W + DIV_MAGIC_W;

    localparam logic signed [TEMP_W-1:0] ERR_TEMP = -15'sd9990;

    typedef struct packed {
        logic [RES_W-1:0] res;
        logic             ok;
    } side_t;

    typedef struct packed {
        logic [E_W-1:0] e;
        side_t          side;
    } front_t;

    typedef struct packed {
        logic [ROOT_W-1:0] s;
        side_t             side;
    } root_t;

endpackage

// File: sv/rtdc_code_if.sv
// Input channel carrying one converter sample per beat.
interface rtdc_code_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

// File: sv/rtdc_result_if.sv
// Output channel carrying one resistance and temperature result per beat.
interface rtdc_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        resistance_centiohm;
    logic signed [14:0] temperature_decidegree;
    logic               in_range;

    modport source (output valid, output resistance_centiohm,
                    output temperature_decidegree, output in_range, input ready);
    modport sink   (input valid, input resistance_centiohm,
                    input temperature_decidegree, input in_range, output ready);
endinterface

// File: sv/rtd_code_to_temperature.sv
// Top level of the PT100 converter from ADC code to resistance and temperature.
// Each beat on samples carries one converter code; each beat on results carries
// the resistance in 0.01 ohm (saturated to 0..65535), the temperature in 0.1 C
// and an in_range flag. Out-of-range resistance (below 100 ohm or above
// 390.48 ohm) gives temperature -9990 with in_range low.
// Calibration is written through cfg_we, cfg_index and cfg_data: index 0 is the
// signed gain times 10000, index 1 the signed offset in milliohm. Write them
// only while no sample is in flight.
// A new sample is taken every cycle while samples.ready is high. A sample
// passes through 6 calibration stages, 32 square root stages (one root bit
// each) and 4 scaling and output stages. Stages advance independently, so a
// stalled receiver holds the output register while empty stages behind it
// keep filling; samples.ready falls only once every stage holds a beat.
// Reset clears all stage valid bits and sets gain to 10000 and offset to 0.
module rtd_code_to_temperature #(
    parameter int ADC_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    rtdc_code_if.sink                samples,
    rtdc_result_if.source            results,
    input  logic                     cfg_we,
    input  rtdc_pkg::cfg_reg_t       cfg_index,
    input  logic [15:0]              cfg_data
);
    import rtdc_pkg::*;

    logic signed [CFG_W-1:0] gain_reg;
    logic signed [CFG_W-1:0] offset_reg;

    logic   front_valid;
    logic   front_ready;
    front_t front_beat;
    logic   root_valid;
    logic   root_ready;
    root_t  root_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_SCALE:      gain_reg   <= $signed(cfg_data);
                REG_OFFSET_MILLIOHM: offset_reg <= $signed(cfg_data);
                default:             ;
            endcase
        end
    end

    rtdc_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .samples         (samples),
        .gain_scale      (gain_reg),
        .offset_milliohm (offset_reg),
        .out_valid       (front_valid),
        .out_ready       (front_ready),
        .out_beat        (front_beat)
    );

    rtdc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_beat   (front_beat),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_beat  (root_beat)
    );

    rtdc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (root_valid),
        .in_ready (root_ready),
        .in_beat  (root_beat),
        .results  (results)
    );

endmodule

// File: sv/rtdc_front.sv
// Front pipeline: calibration, resistance output and scaled discriminant.
module rtdc_front #(
    parameter int ADC_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rtdc_code_if.sink                  samples,
    input  logic signed [15:0]         gain_scale,
    input  logic signed [15:0]         offset_milliohm,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rtdc_pkg::front_t           out_beat
);
    import rtdc_pkg::*;

    localparam int STAGES = 6;
    localparam int C293_W = ADC_BITS + 9;
    localparam int PROD_W = C293_W + 17;
    localparam int N_W    = ADC_BITS + 27;

    typedef struct packed {
        logic pos;
        logic sat;
        logic ok;
    } flags_t;

    logic [STAGES-1:0]         valid_reg;
    logic [STAGES-1:0]         valid_prev;
    logic [STAGES-1:0]         load;

    logic [C293_W-1:0]         c293_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [31:0]        off_reg;
    logic signed [N_W-1:0]     n_reg;
    flags_t                    flags4_reg;
    logic [RES_X_W-1:0]        x_reg;
    logic [D_W-1:0]            d_reg;
    flags_t                    flags5_reg;
    logic [RES_PROD_W-1:0]     rq_reg;
    logic [E_W-1:0]            p231_reg;
    front_t                    out_reg;

    logic signed [63:0]        n_ext;
    logic [63:0]               d_ext;
    flags_t                    flags_next;
    logic [RES_W-1:0]          res_next;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_load
        assign load[k] = out_ready || !(&valid_reg[STAGES-1:k]);
    end

    assign valid_prev    = {valid_reg[STAGES-2:0], samples.valid};
    assign samples.ready = load[0];
    assign out_valid     = valid_reg[STAGES-1];
    assign out_beat      = out_reg;

    always_comb
    begin
        n_ext          = 64'(n_reg);
        d_ext          = 64'(n_ext - N_LOW);
        flags_next.pos = (n_ext > 64'sd0);
        flags_next.sat = (n_ext >= RES_SAT);
        flags_next.ok  = (n_ext >= N_LOW) && (n_ext <= N_HIGH);
        if (flags5_reg.sat)
        begin
            res_next = '1;
        end
        else if (flags5_reg.pos)
        begin
            res_next = rq_reg[RES_MAGIC_SHIFT+RES_W-1:RES_MAGIC_SHIFT];
        end
        else
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_prev[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            c293_reg <= C293_W'(samples.adc_code) * C293_W'(CODE_SLOPE);
        end
        if (load[1])
        begin
            prod_reg <= $signed({1'b0, c293_reg}) * gain_scale;
            off_reg  <= 32'(offset_milliohm) * OFFSET_SCALE;
        end
        if (load[2])
        begin
            n_reg <= N_W'(prod_reg) + N_W'(off_reg) + N_W'(RES_BIAS);
        end
        if (load[3])
        begin
            flags4_reg <= flags_next;
            x_reg      <= n_ext[RES_SHIFT+RES_X_W-1:RES_SHIFT];
            d_reg      <= d_ext[D_W-1:0];
        end
        if (load[4])
        begin
            flags5_reg <= flags4_reg;
            rq_reg     <= RES_PROD_W'(x_reg) * RES_PROD_W'(RES_MAGIC);
            p231_reg   <= E_W'(d_reg) * E_W'(CVD_B);
        end
        if (load[5])
        begin
            out_reg.e        <= E_ZERO - p231_reg;
            out_reg.side.res <= res_next;
            out_reg.side.ok  <= flags5_reg.ok;
        end
    end

endmodule

// File: sv/rtdc_sqrt.sv
// Pipelined restoring square root of E * 2^28 / 375, one result bit per stage.
module rtdc_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rtdc_pkg::front_t  in_beat,
    output logic              out_valid,
    input  logic              out_ready,
    output rtdc_pkg::root_t   out_beat
);
    import rtdc_pkg::*;

    localparam int STAGES = ROOT_W;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_prev;
    logic [STAGES-1:0] load;

    logic [REM_W-1:0]  rem_reg  [STAGES];
    logic [T_W-1:0]    t_reg    [STAGES];
    logic [ROOT_W-1:0] s_reg    [STAGES];
    side_t             side_reg [STAGES];

    logic [REM_W-1:0]  rem_in   [STAGES];
    logic [T_W-1:0]    t_in     [STAGES];
    logic [ROOT_W-1:0] s_in     [STAGES];
    side_t             side_in  [STAGES];
    logic [REM_W-1:0]  delta    [STAGES];
    logic [REM_W-1:0]  rem_next [STAGES];
    logic [T_W-1:0]    t_next   [STAGES];
    logic [ROOT_W-1:0] s_next   [STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_load
        assign load[k] = out_ready || !(&valid_reg[STAGES-1:k]);
    end

    assign valid_prev    = {valid_reg[STAGES-2:0], in_valid};
    assign in_ready      = load[0];
    assign out_valid     = valid_reg[STAGES-1];
    assign out_beat.s    = s_reg[STAGES-1];
    assign out_beat.side = side_reg[STAGES-1];

    // Stage j decides root bit ROOT_W-1-j. The remainder holds E*2^28 - 375*s^2
    // and t holds 375*s, so the trial subtrahend is 375*(2*s*b + b*b).
    always_comb
    begin
        for (int j = 0; j < STAGES; j++)
        begin
            if (j == 0)
            begin
                rem_in[j]  = REM_W'(in_beat.e) << SQ_SHIFT;
                t_in[j]    = '0;
                s_in[j]    = '0;
                side_in[j] = in_beat.side;
            end
            else
            begin
                rem_in[j]  = rem_reg[j-1];
                t_in[j]    = t_reg[j-1];
                s_in[j]    = s_reg[j-1];
                side_in[j] = side_reg[j-1];
            end
            delta[j] = (REM_W'(t_in[j]) << (ROOT_W - j))
                     + (REM_W'(SQ_SCALE) << (2 * (ROOT_W - 1 - j)));
            if (rem_in[j] >= delta[j])
            begin
                rem_next[j] = rem_in[j] - delta[j];
                t_next[j]   = t_in[j] + (T_W'(SQ_SCALE) << (ROOT_W - 1 - j));
                s_next[j]   = s_in[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
            end
            else
            begin
                rem_next[j] = rem_in[j];
                t_next[j]   = t_in[j];
                s_next[j]   = s_in[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_prev[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < STAGES; j++)
        begin
            if (load[j])
            begin
                rem_reg[j]  <= rem_next[j];
                t_reg[j]    <= t_next[j];
                s_reg[j]    <= s_next[j];
                side_reg[j] <= side_in[j];
            end
        end
    end

endmodule

// File: sv/rtdc_back.sv
// Back pipeline: root to decidegrees, error marking and the output register.
module rtdc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rtdc_pkg::root_t  in_beat,
    rtdc_result_if.source    results
);
    import rtdc_pkg::*;

    localparam int STAGES = 4;

    logic [STAGES-1:0]        valid_reg;
    logic [STAGES-1:0]        valid_prev;
    logic [STAGES-1:0]        load;

    logic [ROOT_W-1:0]        diff_reg;
    side_t                    side1_reg;
    logic [Z_W-1:0]           z_reg;
    side_t                    side2_reg;
    logic [M_W-1:0]           m_reg;
    side_t                    side3_reg;
    logic [RES_W-1:0]         res_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     ok_reg;

    logic [Y_W-1:0]           y_next;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_load
        assign load[k] = results.ready || !(&valid_reg[STAGES-1:k]);
    end

    assign valid_prev                     = {valid_reg[STAGES-2:0], in_valid};
    assign in_ready                       = load[0];
    assign results.valid                  = valid_reg[STAGES-1];
    assign results.resistance_centiohm    = res_reg;
    assign results.temperature_decidegree = temp_reg;
    assign results.in_range               = ok_reg;

    assign y_next = Y_W'(diff_reg) * Y_W'(TEMP_NUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_prev[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            diff_reg  <= (in_beat.s < S_ZERO) ? (S_ZERO - in_beat.s) : '0;
            side1_reg <= in_beat.side;
        end
        if (load[1])
        begin
            z_reg     <= y_next[Y_W-1:TEMP_SHIFT];
            side2_reg <= side1_reg;
        end
        if (load[2])
        begin
            m_reg     <= M_W'(z_reg) * M_W'(DIV_MAGIC);
            side3_reg <= side2_reg;
        end
        if (load[3])
        begin
            res_reg  <= side3_reg.res;
            ok_reg   <= side3_reg.ok;
            temp_reg <= side3_reg.ok ? $signed(m_reg[DIV_SHIFT+TEMP_W-1:DIV_SHIFT])
                                     : ERR_TEMP;
        end
    end

endmodule
